@@ rtl/core/bra_pkg.sv @@
// Shared types, constants and helpers for the bitmap run allocator.
// No dependencies; imported by every module of the block but bra_ram.
package bra_pkg;

    localparam int MAP_BITS    = 4096;
    localparam int BIT_W       = 12;
    localparam int LEN_W       = 13;
    localparam int STORE_BYTES = (MAP_BITS + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int OP_W        = 4;

    typedef enum logic [OP_W-1:0] {
        OP_READ        = 4'd0,
        OP_WRITE       = 4'd1,
        OP_SET         = 4'd2,
        OP_CLEAR       = 4'd3,
        OP_INVERT      = 4'd4,
        OP_OFF_TEST    = 4'd5,
        OP_COUNT       = 4'd6,
        OP_RUN_WRAP    = 4'd7,
        OP_RUN_BOUNDED = 4'd8,
        OP_LOAD        = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAN1,
        ST_SCAN2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic begin_scan;
        logic begin_pass2;
        logic scan;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic done;
        logic need_pass2;
        logic found;
    } status_t;

    function automatic logic [3:0] popcount8(input logic [7:0] d);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            c = c + {3'd0, d[k]};
        end
        return c;
    endfunction

endpackage

@@ rtl/core/bitmap_run_allocator.sv @@
// Top level of the bitmap run allocator: 4096-bit allocation map.
// Depends on bra_pkg, bra_ctrl, bra_dp (and bra_ram through bra_dp).
//
// Requests arrive on in_valid/in_ready with one beat per operation; each
// gives exactly one result beat on out_valid/out_ready. cfg_we writes the
// 13-bit length_in_use register at once; write it only while idle.
// After reset the store is swept to zero, one byte per cycle, and in_ready
// stays low until the sweep is done. The map is held as 512 bytes in one
// RAM, and every operation but errors and empty tests walks the bytes of
// its range one per cycle through the single read port, writing modified
// bytes back behind the read. A wrapping run search can make two passes.
// One request is in flight at a time; the next is taken as soon as its
// result is in the output register. If the receiver stalls, a finished
// second result waits in the controller until the first beat is taken.
module bitmap_run_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bra_pkg::OP_W-1:0]    operation,
    input  logic [bra_pkg::LEN_W-1:0]   index_or_length,
    input  logic [bra_pkg::BIT_W-1:0]   range_low,
    input  logic [bra_pkg::LEN_W-1:0]   range_high,
    input  logic                        bit_value,
    input  logic [7:0]                  byte_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        bit_out,
    output logic [bra_pkg::LEN_W-1:0]   value_out,
    output logic                        found,
    output logic                        error,
    input  logic                        cfg_we,
    input  logic [bra_pkg::LEN_W-1:0]   cfg_data
);
    import bra_pkg::*;

    cmd_t    cmd;
    status_t st;

    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    bra_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .operation       (operation),
        .index_or_length (index_or_length),
        .range_low       (range_low),
        .range_high      (range_high),
        .bit_value       (bit_value),
        .byte_data       (byte_data),
        .bit_out         (bit_out),
        .value_out       (value_out),
        .found           (found),
        .error           (error)
    );

endmodule

@@ rtl/core/bra_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bra_dp.sv @@
// Datapath: config register, request registers, byte-wide bitmap store and
// the per-byte scan logic. Depends on bra_pkg and bra_ram.
module bra_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bra_pkg::cmd_t               cmd,
    output bra_pkg::status_t            st,
    input  logic                        cfg_we,
    input  logic [bra_pkg::LEN_W-1:0]   cfg_data,
    input  logic [bra_pkg::OP_W-1:0]    operation,
    input  logic [bra_pkg::LEN_W-1:0]   index_or_length,
    input  logic [bra_pkg::BIT_W-1:0]   range_low,
    input  logic [bra_pkg::LEN_W-1:0]   range_high,
    input  logic                        bit_value,
    input  logic [7:0]                  byte_data,
    output logic                        bit_out,
    output logic [bra_pkg::LEN_W-1:0]   value_out,
    output logic                        found,
    output logic                        error
);
    import bra_pkg::*;

    logic [LEN_W-1:0]  len_reg;
    logic [OP_W-1:0]   op_reg;
    logic [LEN_W-1:0]  idx_reg;
    logic [BIT_W-1:0]  lo_reg;
    logic [LEN_W-1:0]  hi_reg;
    logic              bv_reg;
    logic [7:0]        bd_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] ra_reg;
    logic [ADDR_W-1:0] proc_addr_reg;
    logic              issue_reg;
    logic              proc_valid_reg;
    logic              found_reg;
    logic              pass_reg;
    logic              bit_acc_reg;
    logic [LEN_W-1:0]  value_reg;
    logic [LEN_W-1:0]  run_reg;

    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  sum7;
    logic [ADDR_W:0]   nbytes;
    logic [LEN_W-1:0]  lo_ext;
    logic [LEN_W-1:0]  hi_m1;
    logic [LEN_W-1:0]  cnt_end;
    logic [LEN_W-1:0]  wrap_end2;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  span;
    logic              err;
    logic              skip;
    logic [BIT_W-1:0]  sbit;
    logic [BIT_W-1:0]  ebit;
    logic [ADDR_W-1:0] sa;
    logic [ADDR_W-1:0] ea;

    logic [7:0]        rdata;
    logic [7:0]        mask;
    logic [7:0]        wdata;
    logic              is_wr;
    logic              is_run;
    logic              proc_en;
    logic [LEN_W-1:0]  run_c;
    logic              hit;
    logic [2:0]        hit_k;
    logic [LEN_W-1:0]  hit_pos;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    assign eff_len   = (len_reg > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : len_reg;
    assign sum7      = eff_len + LEN_W'(7);
    assign nbytes    = sum7[LEN_W-1:3];
    assign lo_ext    = {1'b0, lo_reg};
    assign hi_m1     = hi_reg - LEN_W'(1);
    assign cnt_end   = {nbytes, 3'b000} - LEN_W'(1);
    assign wrap_end2 = lo_ext + idx_reg - LEN_W'(2);
    assign len_m1    = eff_len - LEN_W'(1);
    assign span      = hi_reg - lo_ext + LEN_W'(1);

    always_comb
    begin
        case (op_t'(op_reg))
            OP_READ, OP_WRITE:
                err = (idx_reg >= eff_len);
            OP_SET, OP_CLEAR, OP_INVERT:
                err = (hi_reg >= eff_len) || (lo_ext > hi_reg);
            OP_OFF_TEST:
                err = (lo_ext < hi_reg) && (hi_reg > eff_len);
            OP_COUNT:
                err = 1'b0;
            OP_RUN_WRAP:
                err = (idx_reg == '0) || (lo_ext >= eff_len) ||
                      (idx_reg > (eff_len - lo_ext));
            OP_RUN_BOUNDED:
                err = (idx_reg == '0) || (hi_reg >= eff_len) ||
                      (lo_ext > hi_reg) || (idx_reg > span);
            OP_LOAD:
                err = (idx_reg >= LEN_W'(nbytes));
            default:
                err = 1'b1;
        endcase
    end

    always_comb
    begin
        sbit = '0;
        ebit = '0;
        skip = err;
        case (op_t'(op_reg))
            OP_READ, OP_WRITE:
            begin
                sbit = idx_reg[BIT_W-1:0];
                ebit = idx_reg[BIT_W-1:0];
            end
            OP_SET, OP_CLEAR, OP_INVERT, OP_RUN_BOUNDED:
            begin
                sbit = lo_reg;
                ebit = hi_reg[BIT_W-1:0];
            end
            OP_OFF_TEST:
            begin
                sbit = lo_reg;
                ebit = hi_m1[BIT_W-1:0];
                skip = err || (lo_ext >= hi_reg);
            end
            OP_COUNT:
            begin
                ebit = cnt_end[BIT_W-1:0];
                skip = (nbytes == '0);
            end
            OP_RUN_WRAP:
            begin
                if (pass_reg)
                begin
                    ebit = wrap_end2[BIT_W-1:0];
                end
                else
                begin
                    sbit = lo_reg;
                    ebit = len_m1[BIT_W-1:0];
                end
            end
            OP_LOAD:
            begin
                sbit = {idx_reg[ADDR_W-1:0], 3'b000};
                ebit = {idx_reg[ADDR_W-1:0], 3'b111};
            end
            default:
            begin
                skip = 1'b1;
            end
        endcase
    end

    assign sa = sbit[BIT_W-1:3];
    assign ea = ebit[BIT_W-1:3];

    // Bits of the current byte that fall inside the scan range
    assign mask = ((proc_addr_reg == sa) ? (8'hFF << sbit[2:0]) : 8'hFF) &
                  ((proc_addr_reg == ea) ? (8'hFF >> (3'd7 - ebit[2:0])) : 8'hFF);

    always_comb
    begin
        is_wr  = 1'b0;
        is_run = 1'b0;
        wdata  = rdata;
        case (op_t'(op_reg))
            OP_WRITE:
            begin
                is_wr = 1'b1;
                wdata = bv_reg ? (rdata | mask) : (rdata & ~mask);
            end
            OP_SET:
            begin
                is_wr = 1'b1;
                wdata = rdata | mask;
            end
            OP_CLEAR:
            begin
                is_wr = 1'b1;
                wdata = rdata & ~mask;
            end
            OP_INVERT:
            begin
                is_wr = 1'b1;
                wdata = rdata ^ mask;
            end
            OP_LOAD:
            begin
                is_wr = 1'b1;
                wdata = bd_reg;
            end
            OP_RUN_WRAP, OP_RUN_BOUNDED:
            begin
                is_run = 1'b1;
            end
            default:
            begin
                wdata = rdata;
            end
        endcase
    end

    // Run tracking across the eight bits of one byte
    always_comb
    begin
        run_c = run_reg;
        hit   = 1'b0;
        hit_k = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (mask[k] && !hit)
            begin
                if (rdata[k])
                begin
                    run_c = '0;
                end
                else
                begin
                    run_c = run_c + LEN_W'(1);
                    if (run_c == idx_reg)
                    begin
                        hit   = 1'b1;
                        hit_k = 3'(k);
                    end
                end
            end
        end
    end

    assign hit_pos = {1'b0, proc_addr_reg, hit_k} + LEN_W'(1) - idx_reg;
    assign proc_en = cmd.scan && proc_valid_reg && !found_reg;

    assign ram_we    = cmd.clear || (proc_en && is_wr);
    assign ram_waddr = cmd.clear ? clr_addr_reg : proc_addr_reg;
    assign ram_wdata = cmd.clear ? 8'h00 : wdata;

    bra_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ra_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= LEN_W'(MAP_BITS);
            clr_addr_reg   <= '0;
            issue_reg      <= 1'b0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            pass_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.load)
            begin
                issue_reg      <= 1'b0;
                proc_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
                pass_reg       <= 1'b0;
            end
            else if (cmd.begin_scan)
            begin
                issue_reg      <= !skip;
                proc_valid_reg <= 1'b0;
            end
            else if (cmd.begin_pass2)
            begin
                pass_reg       <= 1'b1;
                issue_reg      <= 1'b1;
                proc_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                proc_valid_reg <= issue_reg;
                if (issue_reg && (ra_reg == ea))
                begin
                    issue_reg <= 1'b0;
                end
                if (proc_en && is_run && hit)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            idx_reg     <= index_or_length;
            lo_reg      <= range_low;
            hi_reg      <= range_high;
            bv_reg      <= bit_value;
            bd_reg      <= byte_data;
            bit_acc_reg <= 1'b0;
            value_reg   <= '0;
            run_reg     <= '0;
        end
        else if (cmd.begin_scan)
        begin
            ra_reg <= sa;
        end
        else if (cmd.begin_pass2)
        begin
            ra_reg  <= '0;
            run_reg <= '0;
        end
        else if (cmd.scan)
        begin
            proc_addr_reg <= ra_reg;
            if (issue_reg)
            begin
                ra_reg <= ra_reg + ADDR_W'(1);
            end
            if (proc_en)
            begin
                bit_acc_reg <= bit_acc_reg | (|(rdata & mask));
                if (op_t'(op_reg) == OP_COUNT)
                begin
                    value_reg <= value_reg + LEN_W'(popcount8(rdata));
                end
                if (is_run)
                begin
                    run_reg <= run_c;
                    if (hit)
                    begin
                        value_reg <= hit_pos;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            error     <= err;
            found     <= !err && found_reg;
            value_out <= err ? '0 : value_reg;
            case (op_t'(op_reg))
                OP_READ, OP_WRITE:
                    bit_out <= !err && bit_acc_reg;
                OP_OFF_TEST:
                    bit_out <= !err && !bit_acc_reg;
                default:
                    bit_out <= 1'b0;
            endcase
        end
    end

    assign st.clear_done = (clr_addr_reg == '1);
    assign st.done       = (!issue_reg && !proc_valid_reg) || found_reg;
    assign st.need_pass2 = (op_t'(op_reg) == OP_RUN_WRAP) && !pass_reg &&
                           (lo_reg != '0) && !found_reg && !err;
    assign st.found      = found_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !cmd.clear) |-> !err)
        else $error("store written by a rejected request");

    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> is_run)
        else $error("run found flag set for a non-search operation");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.begin_pass2 |-> (op_t'(op_reg) == OP_RUN_WRAP))
        else $error("second pass started for a bounded request");

endmodule

@@ rtl/core/bra_ctrl.sv @@
// Controller state machine: store clearing, request sequencing, scan passes
// and the result handshake. Depends on bra_pkg.
module bra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output bra_pkg::cmd_t    cmd,
    input  bra_pkg::status_t st
);
    import bra_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (st.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.begin_scan = 1'b1;
                state_next     = ST_SCAN1;
            end
            ST_SCAN1:
            begin
                if (!st.done)
                begin
                    cmd.scan = 1'b1;
                end
                else if (st.need_pass2)
                begin
                    cmd.begin_pass2 = 1'b1;
                    state_next      = ST_SCAN2;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN2:
            begin
                if (!st.done)
                begin
                    cmd.scan = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("request taken during store clearing");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.begin_pass2 |-> !st.found)
        else $error("second pass after a run was found");

endmodule
